@@ rtl/bls_pkg.sv @@
// Shared types and constants for the Bresenham line stepper.
// Used by bls_step and by the top level; no dependencies.
package bls_pkg;

  localparam int COLOR_BITS = 4;
  localparam logic [COLOR_BITS-1:0] COLOR_RESET = 4'd4;

  typedef enum logic {
    MODE_START = 1'b0,
    MODE_STEP  = 1'b1
  } mode_t;

endpackage

@@ rtl/bls_step.sv @@
// Line state, setup and per-pixel step logic of the Bresenham line stepper.
// Holds the color register and gives the result of an accepted beat combinationally.
// Depends on bls_pkg.
module bls_step
  import bls_pkg::*;
#(
  parameter int COORD_BITS = 11
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [COLOR_BITS-1:0] cfg_wr_data,
  input  logic                  accept,
  input  mode_t                 mode,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  output logic                  res_valid,
  output logic [COORD_BITS-1:0] res_x,
  output logic [COORD_BITS-1:0] res_y,
  output logic [COLOR_BITS-1:0] res_color,
  output logic                  res_last
);

  localparam int DW = COORD_BITS + 3;
  localparam int SW = COORD_BITS + 1;

  logic [COLOR_BITS-1:0] color_r;
  logic [COORD_BITS-1:0] cur_x_r, cur_x_nxt;
  logic [COORD_BITS-1:0] cur_y_r, cur_y_nxt;
  logic [DW-1:0]         decision_r, decision_nxt;
  logic [DW-1:0]         inc_straight_r, inc_straight_nxt;
  logic [DW-1:0]         inc_diagonal_r, inc_diagonal_nxt;
  logic [SW-1:0]         steps_left_r, steps_left_nxt;
  logic                  x_is_major_r, x_is_major_nxt;
  logic                  x_negative_r, x_negative_nxt;
  logic                  y_negative_r, y_negative_nxt;
  logic                  busy_r, busy_nxt;

  logic                  x_neg, y_neg, x_maj, diag;
  logic [COORD_BITS-1:0] adx, ady, major, minor;
  logic [DW-1:0]         diff;

  always_comb begin
    x_neg = end_x < start_x;
    y_neg = end_y < start_y;
    adx   = x_neg ? (start_x - end_x) : (end_x - start_x);
    ady   = y_neg ? (start_y - end_y) : (end_y - start_y);
    x_maj = adx >= ady;
    major = x_maj ? adx : ady;
    minor = x_maj ? ady : adx;
    diff  = {3'b000, minor} - {3'b000, major};
    diag  = !decision_r[DW-1];

    cur_x_nxt        = cur_x_r;
    cur_y_nxt        = cur_y_r;
    decision_nxt     = decision_r;
    inc_straight_nxt = inc_straight_r;
    inc_diagonal_nxt = inc_diagonal_r;
    steps_left_nxt   = steps_left_r;
    x_is_major_nxt   = x_is_major_r;
    x_negative_nxt   = x_negative_r;
    y_negative_nxt   = y_negative_r;
    busy_nxt         = busy_r;

    res_valid = 1'b0;
    res_x     = '0;
    res_y     = '0;
    res_color = '0;
    res_last  = 1'b0;

    case (mode)
      MODE_START: begin
        cur_x_nxt        = start_x;
        cur_y_nxt        = start_y;
        inc_straight_nxt = {2'b00, minor, 1'b0};
        inc_diagonal_nxt = {diff[DW-2:0], 1'b0};
        decision_nxt     = {2'b00, minor, 1'b0} - {3'b000, major};
        steps_left_nxt   = {1'b0, major};
        x_is_major_nxt   = x_maj;
        x_negative_nxt   = x_neg;
        y_negative_nxt   = y_neg;
        busy_nxt         = major != '0;
        res_valid        = 1'b1;
        res_x            = start_x;
        res_y            = start_y;
        res_color        = color_r;
        res_last         = major == '0;
      end
      MODE_STEP: begin
        if (busy_r) begin
          decision_nxt = decision_r + (diag ? inc_diagonal_r : inc_straight_r);
          if (x_is_major_r || diag) begin
            cur_x_nxt = x_negative_r ? cur_x_r - COORD_BITS'(1) : cur_x_r + COORD_BITS'(1);
          end
          if (!x_is_major_r || diag) begin
            cur_y_nxt = y_negative_r ? cur_y_r - COORD_BITS'(1) : cur_y_r + COORD_BITS'(1);
          end
          steps_left_nxt = steps_left_r - SW'(1);
          busy_nxt       = steps_left_nxt != '0;
          res_valid      = 1'b1;
          res_x          = cur_x_nxt;
          res_y          = cur_y_nxt;
          res_color      = color_r;
          res_last       = !busy_nxt;
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r <= COLOR_RESET;
    end else if (cfg_wr_en) begin
      color_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r        <= '0;
      cur_y_r        <= '0;
      decision_r     <= '0;
      inc_straight_r <= '0;
      inc_diagonal_r <= '0;
      steps_left_r   <= '0;
      x_is_major_r   <= 1'b0;
      x_negative_r   <= 1'b0;
      y_negative_r   <= 1'b0;
      busy_r         <= 1'b0;
    end else if (accept) begin
      cur_x_r        <= cur_x_nxt;
      cur_y_r        <= cur_y_nxt;
      decision_r     <= decision_nxt;
      inc_straight_r <= inc_straight_nxt;
      inc_diagonal_r <= inc_diagonal_nxt;
      steps_left_r   <= steps_left_nxt;
      x_is_major_r   <= x_is_major_nxt;
      x_negative_r   <= x_negative_nxt;
      y_negative_r   <= y_negative_nxt;
      busy_r         <= busy_nxt;
    end
  end

`ifndef SYNTHESIS
  a_busy_has_steps: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> steps_left_r != '0)
    else $error("busy line with no steps left");
  a_idle_no_steps: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> steps_left_r == '0)
    else $error("idle line with steps left");
  a_last_step_idles: assert property (@(posedge clk) disable iff (!rst_n)
    accept && mode == MODE_STEP && busy_r && steps_left_r == SW'(1) |=> !busy_r)
    else $error("line still busy after its last pixel");
`endif

endmodule

@@ rtl/bls_out_skid.sv @@
// Output register with one skid entry for the Bresenham line stepper.
// Generic over the payload width; no dependencies.
module bls_out_skid #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic             out_valid_r, out_valid_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  logic [WIDTH-1:0] out_data_r, out_data_nxt;
  logic [WIDTH-1:0] skid_data_r, skid_data_nxt;
  logic             push, pop;

  assign in_ready  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid_r && out_ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else if (push) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = in_data;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register is empty");
  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && out_ready |=> out_valid_r && !skid_valid_r)
    else $error("skid entry not moved to output register");
  a_direct_load: assert property (@(posedge clk) disable iff (!rst_n)
    push && !out_valid_r |=> out_valid_r && !skid_valid_r)
    else $error("beat into empty stage did not land in output register");
`endif

endmodule

@@ rtl/bresenham_line_stepper.sv @@
// Bresenham line stepper top level: one pixel result per input beat, eight octants.
// Each result beat is registered in the output register, or in the skid entry while the output stalls.
// Throughput is one beat per cycle while in_tready is high; the step registers update only on an accepted beat.
// A one-entry skid lets one more input beat be accepted while a result waits for out_tready.
// Reset (rst_n low, synchronous) makes the stepper idle and sets the pixel color to 4.
// Depends on bls_pkg, bls_step and bls_out_skid.
module bresenham_line_stepper
  import bls_pkg::*;
#(
  parameter int COORD_BITS = 11
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [COLOR_BITS-1:0]             cfg_wr_data,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // start_x, start_y, end_x, end_y from the lowest bit up, zero padded.
  input  logic [((4*COORD_BITS+7)/8)*8-1:0] in_tdata,
  // mode.
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // pixel_x, pixel_y, color from the lowest bit up, zero padded.
  output logic [((2*COORD_BITS+COLOR_BITS+7)/8)*8-1:0] out_tdata,
  // pixel_valid.
  output logic                              out_tuser,
  output logic                              out_tlast
);

  localparam int C      = COORD_BITS;
  localparam int PIX_W  = 2 * C + COLOR_BITS;
  localparam int OUT_W  = ((PIX_W + 7) / 8) * 8;
  localparam int SKID_W = PIX_W + 2;

  logic                  accept;
  logic                  res_valid, res_last;
  logic [C-1:0]          res_x, res_y;
  logic [COLOR_BITS-1:0] res_color;
  logic [SKID_W-1:0]     res_data, held_data;

  assign accept = in_tvalid && in_tready;

  bls_step #(
    .COORD_BITS(COORD_BITS)
  ) u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .accept     (accept),
    .mode       (mode_t'(in_tuser)),
    .start_x    (in_tdata[C-1:0]),
    .start_y    (in_tdata[2*C-1:C]),
    .end_x      (in_tdata[3*C-1:2*C]),
    .end_y      (in_tdata[4*C-1:3*C]),
    .res_valid  (res_valid),
    .res_x      (res_x),
    .res_y      (res_y),
    .res_color  (res_color),
    .res_last   (res_last)
  );

  assign res_data = {res_last, res_valid, res_color, res_y, res_x};

  bls_out_skid #(
    .WIDTH(SKID_W)
  ) u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_data  (res_data),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_data (held_data)
  );

  assign out_tdata = OUT_W'(held_data[PIX_W-1:0]);
  assign out_tuser = held_data[PIX_W];
  assign out_tlast = held_data[PIX_W+1];

endmodule
